/* hw/rtl/rx_descriptor_ring_consumer_defines.svh */
// Assertion macros shared by the receive descriptor ring consumer RTL.
`ifndef RX_DESCRIPTOR_RING_CONSUMER_DEFINES_SVH
`define RX_DESCRIPTOR_RING_CONSUMER_DEFINES_SVH
`ifndef SYNTH
// Clocked property that is ignored while reset is asserted.
`define RDRC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property that is checked during reset as well.
`define RDRC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDRC_ASSERT(label, clk, rst_n, prop, msg)
`define RDRC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/rdrc_pkg.sv */
// Shared types and constants of the receive descriptor ring consumer.
`default_nettype none

package rdrc_pkg;

    localparam int DEF_RING_DEPTH = 16;
    localparam int SCAN_LANES     = 16;
    localparam int LEN_W          = 14;
    localparam int SLOT_W         = 4;
    localparam int STATUS_W       = 3;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    localparam logic [LEN_W-1:0] FCS_BYTES = LEN_W'(4);

    // Codes of the item's action field.
    localparam logic ACT_COMPLETE = 1'b0;
    localparam logic ACT_POLL     = 1'b1;

    // Register index as seen in paddr[ADDR_W-1].
    localparam logic REG_DEVICE_ENABLED = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_DELIVERED = 3'd2,
        ST_ERROR     = 3'd3,
        ST_RUNT      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMPLETE,
        S_EMPTY,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic latch;       // capture the item and start a scan at the cursor
        logic write;       // store a completion and hand the slot to the host
        logic step;        // examine the next chunk of the ring
        logic consume;     // report the found slot and repost it
        logic emit_empty;  // report an empty poll
    } t_ctrl_cmd;

    typedef struct packed {
        logic hit;         // a host-owned slot is in the current chunk
        logic last_chunk;  // the current chunk completes one turn of the ring
    } t_dp_status;

endpackage

`default_nettype wire

/* hw/rtl/rx_descriptor_ring_consumer.sv */
// Top level of the receive descriptor ring consumer: config register, control and datapath.
// A result strobes on o_done once its item is done. A poll scans the ring from the cursor in
// chunks set by the 16-slot scan window, until it finds a host-owned slot or has seen one turn.
// Synchronous active-low reset gives every slot to the NIC, zeroes cursor and enable, no sweep.
// Results cannot be stalled: each is shown for exactly one cycle.
`default_nettype none
`include "rx_descriptor_ring_consumer_defines.svh"

module rx_descriptor_ring_consumer
    import rdrc_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    // Item command port.
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_action,
    input  wire logic [SLOT_W-1:0]   i_slot_index,
    input  wire logic [LEN_W-1:0]    i_packet_length,
    input  wire logic                i_error_summary,
    input  wire logic [LEN_W-1:0]    i_buffer_capacity,

    // Result port.
    output logic                     o_done,
    output logic [STATUS_W-1:0]      o_status,
    output logic [LEN_W-1:0]         o_frame_length,
    output logic [SLOT_W-1:0]        o_consumed_slot,
    output logic                     o_resynced,

    // Configuration port.
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    // The only register is the device enable. While it is clear, every poll
    // reports an empty ring and leaves the ring state alone; completions are
    // still recorded. The user writes it only while idle; the block does not enforce it.
    logic r_device_enabled;
    logic cfg_write;
    logic reg_sel;

    t_ctrl_cmd  cmd;
    t_dp_status dp_stat;

    // A result carries a length only when it delivers a frame.
    logic len_ok;

    assign pready    = 1'b1;
    assign reg_sel   = (paddr[ADDR_W-1] == REG_DEVICE_ENABLED);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_enabled <= 1'b0;
        end else if (cfg_write && reg_sel) begin
            r_device_enabled <= pwdata[0];
        end
    end

    // Reads return the enable bit at its address and zero elsewhere.
    assign prdata = reg_sel ? {{(DATA_W - 1){1'b0}}, r_device_enabled} : '0;

    // The controller accepts an item in its idle state and walks it through
    // the completion write, the empty report or the ring scan. It sees the
    // datapath only through the command and status structs.
    rdrc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_action  (i_action),
        .i_enabled (r_device_enabled),
        .i_stat    (dp_stat),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    // The datapath holds the ownership bits, the descriptor memory, the
    // cursor and the scan window, and registers every result it reports.
    rdrc_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_slot_index      (i_slot_index),
        .i_packet_length   (i_packet_length),
        .i_error_summary   (i_error_summary),
        .i_buffer_capacity (i_buffer_capacity),
        .o_stat            (dp_stat),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_frame_length    (o_frame_length),
        .o_consumed_slot   (o_consumed_slot),
        .o_resynced        (o_resynced)
    );

    assign len_ok = (o_status == ST_DELIVERED) || (o_frame_length == '0);

    // An accepted item always keeps the block busy in the following cycle.
    `RDRC_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accept without busy")
    // A result only follows a cycle of work.
    `RDRC_ASSERT(a_done_after_work, i_clk, i_rst_n, o_done |-> $past(busy), "result from idle")
    // Only a delivered frame carries a length.
    `RDRC_ASSERT(a_len_only_delivered, i_clk, i_rst_n, o_done |-> len_ok, "stray frame length")
    // Reset leaves no result pending and the controller idle.
    `RDRC_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!o_done && !busy), "busy after reset")

endmodule

`default_nettype wire

/* hw/rtl/rdrc_ctrl.sv */
// Sequencing state machine of the receive descriptor ring consumer.
`default_nettype none

module rdrc_ctrl
    import rdrc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_action,
    input  wire logic       i_enabled,
    input  wire t_dp_status i_stat,
    output t_ctrl_cmd       o_cmd,
    output logic            o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == ACT_COMPLETE) begin
                        n_state = S_COMPLETE;
                    end else if (!i_enabled) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_COMPLETE: n_state = S_IDLE;
            S_EMPTY:    n_state = S_IDLE;
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_state = S_FINISH;
                end else if (i_stat.last_chunk) begin
                    n_state = S_IDLE;
                end
            end
            S_FINISH:   n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy      = 1'b0;
                o_cmd.latch = i_start;
            end
            S_COMPLETE: o_cmd.write = 1'b1;
            S_EMPTY:    o_cmd.emit_empty = 1'b1;
            S_SCAN: begin
                o_cmd.step       = 1'b1;
                o_cmd.emit_empty = !i_stat.hit && i_stat.last_chunk;
            end
            S_FINISH:   o_cmd.consume = 1'b1;
            default:    o_busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/rdrc_datapath.sv */
// Ring state, descriptor memory, chunked ownership scan and result registers.
`default_nettype none

module rdrc_datapath
    import rdrc_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ctrl_cmd         i_cmd,
    input  wire logic [SLOT_W-1:0] i_slot_index,
    input  wire logic [LEN_W-1:0]  i_packet_length,
    input  wire logic              i_error_summary,
    input  wire logic [LEN_W-1:0]  i_buffer_capacity,
    output t_dp_status             o_stat,
    output logic                   o_done,
    output logic [STATUS_W-1:0]    o_status,
    output logic [LEN_W-1:0]       o_frame_length,
    output logic [SLOT_W-1:0]      o_consumed_slot,
    output logic                   o_resynced
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int LANES = (RING_DEPTH < SCAN_LANES) ? RING_DEPTH : SCAN_LANES;
    localparam int CNT_W = $clog2(RING_DEPTH + LANES + 1);

    localparam logic [IDX_W:0]   DEPTH_I = (IDX_W + 1)'(RING_DEPTH);
    localparam logic [IDX_W:0]   LANES_I = (IDX_W + 1)'(LANES);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0] LANES_C = CNT_W'(LANES);

    // Latched item.
    logic [SLOT_W-1:0] r_slot;
    logic [LEN_W-1:0]  r_length;
    logic              r_error;
    logic [LEN_W-1:0]  r_cap;

    // Ring bookkeeping.
    logic [RING_DEPTH-1:0] r_nic_owns;
    logic [IDX_W-1:0]      r_cursor;
    logic [IDX_W-1:0]      r_pos;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_found;

    // Descriptor memory: {length, error} per slot.
    logic [LEN_W:0] r_mem [RING_DEPTH];
    logic [LEN_W:0] r_rd_word;

    // Result registers.
    logic                r_done;
    t_status             r_status;
    logic [LEN_W-1:0]    r_frame_length;
    logic [SLOT_W-1:0]   r_consumed_slot;
    logic                r_resynced;

    logic             slot_in_ring;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] lane_idx [LANES];
    logic [LANES-1:0] lane_host;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W:0]   pos_sum;
    logic [IDX_W-1:0] n_pos;
    logic [IDX_W:0]   cur_sum;
    logic [IDX_W-1:0] n_cursor;
    logic [LEN_W-1:0] rd_len;
    logic             rd_err;
    logic [LEN_W-1:0] trimmed;
    t_status          fin_status;
    logic [LEN_W-1:0] fin_len;

    assign slot_in_ring = (int'(r_slot) < RING_DEPTH);
    assign wr_addr      = IDX_W'(r_slot);

    // Lane k looks at slot (pos + k) mod depth. Lanes that run past one full
    // turn revisit slots already seen as NIC-owned, so they never hit.
    always_comb begin
        logic [IDX_W:0] sum;
        sum = '0;
        for (int k = 0; k < LANES; k++) begin
            sum = {1'b0, r_pos} + (IDX_W + 1)'(k);
            if (sum >= DEPTH_I) begin
                sum = sum - DEPTH_I;
            end
            lane_idx[k]  = sum[IDX_W-1:0];
            lane_host[k] = !r_nic_owns[lane_idx[k]];
        end
    end

    always_comb begin
        hit     = |lane_host;
        hit_idx = lane_idx[0];
        for (int k = LANES - 1; k >= 0; k--) begin
            if (lane_host[k]) begin
                hit_idx = lane_idx[k];
            end
        end
    end

    always_comb begin
        pos_sum = {1'b0, r_pos} + LANES_I;
        if (pos_sum >= DEPTH_I) begin
            pos_sum = pos_sum - DEPTH_I;
        end
        n_pos = pos_sum[IDX_W-1:0];
    end

    always_comb begin
        cur_sum = {1'b0, r_found} + (IDX_W + 1)'(1);
        if (cur_sum >= DEPTH_I) begin
            cur_sum = '0;
        end
        n_cursor = cur_sum[IDX_W-1:0];
    end

    assign o_stat.hit        = hit;
    assign o_stat.last_chunk = ((r_count + LANES_C) >= DEPTH_C);

    // Classification of the found descriptor.
    assign rd_len  = r_rd_word[LEN_W:1];
    assign rd_err  = r_rd_word[0];
    assign trimmed = rd_len - FCS_BYTES;

    always_comb begin
        fin_len = '0;
        priority if (rd_err) begin
            fin_status = ST_ERROR;
        end else if (rd_len < FCS_BYTES) begin
            fin_status = ST_RUNT;
        end else begin
            fin_status = ST_DELIVERED;
            fin_len    = (trimmed > r_cap) ? r_cap : trimmed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_slot   <= i_slot_index;
            r_length <= i_packet_length;
            r_error  <= i_error_summary;
            r_cap    <= i_buffer_capacity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && slot_in_ring) begin
            r_mem[wr_addr] <= {r_length, r_error};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && hit) begin
            r_rd_word <= r_mem[hit_idx];
            r_found   <= hit_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nic_owns <= '1;
            r_cursor   <= '0;
        end else begin
            if (i_cmd.write && slot_in_ring) begin
                r_nic_owns[wr_addr] <= 1'b0;
            end
            if (i_cmd.consume) begin
                r_nic_owns[r_found] <= 1'b1;
                r_cursor            <= n_cursor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_pos   <= r_cursor;
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_pos   <= n_pos;
            r_count <= r_count + LANES_C;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.write || i_cmd.consume || i_cmd.emit_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_status        <= ST_ACCEPTED;
            r_frame_length  <= '0;
            r_consumed_slot <= '0;
            r_resynced      <= 1'b0;
        end else if (i_cmd.consume) begin
            r_status        <= fin_status;
            r_frame_length  <= fin_len;
            r_consumed_slot <= SLOT_W'(r_found);
            r_resynced      <= (r_found != r_cursor);
        end else if (i_cmd.emit_empty) begin
            r_status        <= ST_EMPTY;
            r_frame_length  <= '0;
            r_consumed_slot <= '0;
            r_resynced      <= 1'b0;
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_frame_length  = r_frame_length;
    assign o_consumed_slot = r_consumed_slot;
    assign o_resynced      = r_resynced;

endmodule

`default_nettype wire
